### hdl/smpq_pkg.sv
`default_nettype none

package smpq_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fixed field widths of the stream payloads.
  localparam int unsigned FieldKeyW   = 32;
  localparam int unsigned FieldCountW = 5;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned InUserW     = 2;
  localparam int unsigned OutDataW    = 72;
  localparam int unsigned OutUserW    = 3;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic ins;         // shift-insert the new key this cycle
    logic signed_cmp;  // compare keys as two's complement
  } smpq_ctrl_t;

endpackage

`default_nettype wire

### hdl/smpq_cell.sv
`default_nettype none

module smpq_cell
  import smpq_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire smpq_ctrl_t           ctrl_i,
  input  wire logic [KEY_WIDTH-1:0] key_new_i,
  input  wire logic                 slot_valid_i,
  input  wire logic                 all_lt_i,
  input  wire logic [KEY_WIDTH-1:0] left_key_i,
  output logic                      all_lt_o,
  output logic [KEY_WIDTH-1:0]      key_o
);

  localparam logic [KEY_WIDTH-1:0] SignBit = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] flip;
  logic                 my_lt;

  // Flipping the sign bit turns a signed compare into an unsigned one.
  assign flip     = ctrl_i.signed_cmp ? SignBit : '0;
  assign my_lt    = slot_valid_i && ((key_q ^ flip) < (key_new_i ^ flip));
  assign all_lt_o = all_lt_i & my_lt;
  assign key_o    = key_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      if (!all_lt_i) begin
        key_q <= left_key_i;
      end else if (!my_lt) begin
        key_q <= key_new_i;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/sorted_max_priority_queue.sv
// An input transfer sets the busy flag, and an insert shifts the cell row. The
// result moves to the output register once that is free, with the new top key
// read from the registered row; no item is taken while a result is pending.
// Reset (rst_ni, asynchronous, active low) empties the queue, drops any pending
// result and selects unsigned compare. Key cells are not cleared.
`default_nettype none

module sorted_max_priority_queue
  import smpq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write channel: bit 0 is signed_compare.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [31:0] new_key
  input  wire logic [InUserW-1:0]  s_axis_tuser,   // [1:0] operation
  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [31:0] removed_key, [63:32] max_key, [68:64] entry_count,
  // [69] queue_empty, [71:70] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] removed_valid, [2:1] status
  output logic [OutUserW-1:0]      m_axis_tuser
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  // The queue is a row of cells in ascending order: cell 0 holds the
  // smallest key and cell count-1 the maximum. Each cell compares its key
  // against the incoming key, and a prefix-AND of "less than" ripples along
  // the row. The first cell where that chain breaks takes the new key and
  // every cell above it takes its lower neighbor's key, so an insert is one
  // shift of the whole row. A remove only lowers the count.

  logic                 signed_q;
  logic                 busy_q;
  logic [CntW-1:0]      count_q;
  logic [KEY_WIDTH-1:0] top_q;
  logic [KEY_WIDTH-1:0] pend_removed_q;
  logic                 pend_rvalid_q;
  logic [1:0]           pend_status_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic [OutUserW-1:0]  out_user_q;

  logic                 accept;
  logic                 finish;
  logic [1:0]           op;
  logic [KEY_WIDTH-1:0] key_new;
  logic                 full;
  smpq_ctrl_t           ctrl;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY:0]    all_lt;
  logic [IdxW-1:0]      top_idx;
  logic [KEY_WIDTH-1:0] top_sel;
  logic [63:0]          top_wide;
  logic [63:0]          rem_wide;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // The pending result moves to the output register once that is free.
  assign finish        = busy_q && (!out_valid_q || m_axis_tready);

  assign op      = s_axis_tuser;
  assign key_new = KEY_WIDTH'(s_axis_tdata);
  assign full    = (count_q == CntW'(CAPACITY));

  always_comb begin
    ctrl.signed_cmp = signed_q;
    ctrl.ins        = accept && (op == OP_INSERT) && !full;
  end

  assign all_lt[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    if (i == 0) begin : g_first
      assign left_key = key_new;
    end else begin : g_rest
      assign left_key = cell_key[i-1];
    end

    smpq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_new_i    (key_new),
      .slot_valid_i (count_q > CntW'(i)),
      .all_lt_i     (all_lt[i]),
      .left_key_i   (left_key),
      .all_lt_o     (all_lt[i+1]),
      .key_o        (cell_key[i])
    );
  end

  // The top key after the shift is read from the registered row.
  assign top_idx  = IdxW'(count_q - CntW'(1));
  assign top_sel  = (count_q != '0) ? cell_key[top_idx] : '0;
  assign top_wide = 64'(top_sel);
  assign rem_wide = 64'(pend_removed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q      <= 1'b0;
      busy_q        <= 1'b0;
      count_q       <= '0;
      pend_rvalid_q <= 1'b0;
      pend_status_q <= ST_OK;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        signed_q <= cfg_data_i;
      end

      if (accept) begin
        busy_q        <= 1'b1;
        pend_rvalid_q <= 1'b0;
        pend_status_q <= ST_OK;
        case (op)
          OP_INSERT: begin
            if (full) begin
              pend_status_q <= ST_FULL;
            end else begin
              count_q <= count_q + CntW'(1);
            end
          end
          OP_REMOVE: begin
            if (count_q == '0) begin
              pend_status_q <= ST_EMPTY;
            end else begin
              count_q       <= count_q - CntW'(1);
              pend_rvalid_q <= 1'b1;
            end
          end
          OP_CLEAR: begin
            count_q <= '0;
          end
          default: begin
          end
        endcase
      end else if (finish) begin
        busy_q <= 1'b0;
      end

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_removed_q <= (op == OP_REMOVE && count_q != '0) ? top_q : '0;
    end
    if (finish) begin
      top_q      <= top_sel;
      out_data_q <= {2'b00, (count_q == '0), FieldCountW'(count_q),
                     top_wide[FieldKeyW-1:0], rem_wide[FieldKeyW-1:0]};
      out_user_q <= {pend_status_q, pend_rvalid_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted item left no pending result");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_REMOVE && count_q != '0) |=>
      (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not lower the count by one");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_q && !m_axis_tready) |=> busy_q)
    else $error("pending result lost while output stalled");
`endif

endmodule

`default_nettype wire

### test/tb_sorted_max_priority_queue.sv
`default_nettype none

module tb_sorted_max_priority_queue
  import smpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_WIDTH = 32;
  // Operation code 3 is unused by the block and must behave as a no-op.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int unsigned MAX_GAP = 13;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 315;

  // One result of the queue, split into its fields.
  typedef struct packed {
    logic [31:0] removed_key;
    logic        removed_valid;
    logic [1:0]  status;
    logic [31:0] max_key;
    logic [4:0]  entry_count;
    logic        queue_empty;
  } outcome_t;

  // Tracks the queue contents the block should hold and the results that
  // each accepted operation should produce, then checks results in order.
  class pq_tracker;
    logic [KEY_WIDTH-1:0] held_keys [CAPACITY];
    int unsigned held;
    bit signed_mode;
    outcome_t outcome_q[$];
    int unsigned errors;
    int unsigned n_ops;
    int unsigned n_checked;
    int unsigned n_removed;
    int unsigned n_empty;
    int unsigned n_full;

    function new();
      held = 0;
      signed_mode = 1'b0;
      errors = 0;
      n_ops = 0;
      n_checked = 0;
      n_removed = 0;
      n_empty = 0;
      n_full = 0;
    endfunction

    function bit key_below(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
      if (signed_mode) begin
        return $signed(a) < $signed(b);
      end
      return a < b;
    endfunction

    // Applies one accepted operation and queues the result it must cause.
    function void note_op(logic [1:0] op, logic [31:0] key);
      outcome_t o;
      int unsigned pos;
      o = '0;
      o.status = ST_OK;
      n_ops++;
      case (op)
        OP_INSERT: begin
          if (held >= CAPACITY) begin
            o.status = ST_FULL;
          end else begin
            // The new key lands below every equal key, so equal keys
            // leave in arrival order.
            pos = 0;
            while (pos < held && key_below(held_keys[pos], key)) pos++;
            for (int unsigned j = held; j > pos; j--) held_keys[j] = held_keys[j-1];
            held_keys[pos] = key;
            held++;
          end
        end
        OP_REMOVE: begin
          if (held == 0) begin
            o.status = ST_EMPTY;
          end else begin
            held--;
            o.removed_key = held_keys[held];
            o.removed_valid = 1'b1;
          end
        end
        OP_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      if (held > 0) o.max_key = held_keys[held-1];
      o.entry_count = 5'(held);
      o.queue_empty = (held == 0);
      outcome_q.push_back(o);
    endfunction

    // Compares one result transfer with the oldest pending expectation.
    function void check_outcome(logic [OutDataW-1:0] data, logic [OutUserW-1:0] user);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        $error("result with nothing pending: tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      want = outcome_q.pop_front();
      n_checked++;
      if (want.removed_valid) n_removed++;
      if (want.status == ST_EMPTY) n_empty++;
      if (want.status == ST_FULL) n_full++;
      if (data[31:0] !== want.removed_key) begin
        $error("removed_key: expected %h, got %h", want.removed_key, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.max_key) begin
        $error("max_key: expected %h, got %h", want.max_key, data[63:32]);
        errors++;
      end
      if (data[68:64] !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, data[68:64]);
        errors++;
      end
      if (data[69] !== want.queue_empty) begin
        $error("queue_empty: expected %b, got %b", want.queue_empty, data[69]);
        errors++;
      end
      if (data[71:70] !== 2'b00) begin
        $error("tdata padding: expected 00, got %b", data[71:70]);
        errors++;
      end
      if (user[0] !== want.removed_valid) begin
        $error("removed_valid: expected %b, got %b", want.removed_valid, user[0]);
        errors++;
      end
      if (user[2:1] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, user[2:1]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic [InUserW-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  pq_tracker tracker;
  // When set, the matching side runs with no idle cycles at all.
  bit in_calm;
  bit out_calm;
  int unsigned cycles = 0;

  sorted_max_priority_queue #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // All driver tasks start and end at a falling edge. Inputs change there and
  // handshakes are sampled at the rising edge, so no race with the block.

  // Offers one operation and returns once the block has taken the transfer.
  // With no idle cycles drawn, tvalid simply stays high into the next item.
  task automatic push_op(logic [1:0] op, logic [31:0] key);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= key;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_op(op, key);
    @(negedge clk_i);
  endtask

  // Drops tvalid and waits until every pending result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(negedge clk_i);
  endtask

  // Changes the compare mode only once the block is idle. Idle cycles separate
  // the last result from the write.
  task automatic write_mode(bit mode);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.signed_mode = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Keys lean toward the values where unsigned and signed order disagree,
  // and toward tight clusters so that equal keys are common.
  function automatic logic [31:0] draw_key();
    logic [31:0] base;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      1, 2, 3: begin
        case ($urandom_range(0, 2))
          0: base = 32'h0000_0000;
          1: base = 32'hFFFF_FFFE;
          default: base = 32'h7FFF_FFFE;
        endcase
        return base + $urandom_range(0, 3);
      end
      default: return $urandom();
    endcase
  endfunction

  // Rare clears and no-ops; the rest splits between insert and remove with a
  // bias that sends the queue toward full, toward empty, or around the middle.
  function automatic logic [1:0] draw_op(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_CLEAR;
    if (r < 4) return OP_NOP;
    if (r < 4 + insert_pct) return OP_INSERT;
    return OP_REMOVE;
  endfunction

  task automatic run_random(int unsigned count, bit pause_midway);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      // Hold the sender once until the block has answered everything.
      if (pause_midway && i == count / 2) drain_results();
      push_op(draw_op(insert_pct), draw_key());
    end
  endtask

  // Result side: random backpressure per result, every transfer checked.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_outcome(m_axis_tdata, m_axis_tuser);
      @(negedge clk_i);
    end
  end

  initial begin
    tracker = new();
    in_calm = 1'b0;
    out_calm = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_INSERT;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_mode(1'b0);

    // Directed part in unsigned mode: empty-queue corner cases first.
    push_op(OP_REMOVE, 32'h0);
    push_op(OP_NOP, 32'hFFFF_FFFF);
    push_op(OP_CLEAR, 32'h0);
    // Key extremes, including the sign boundary and a repeated key.
    push_op(OP_INSERT, 32'h0000_0000);
    push_op(OP_INSERT, 32'hFFFF_FFFF);
    push_op(OP_INSERT, 32'h8000_0000);
    push_op(OP_INSERT, 32'h7FFF_FFFF);
    push_op(OP_INSERT, 32'h8000_0000);
    push_op(OP_REMOVE, 32'h0);
    push_op(OP_NOP, 32'h0);
    // Fill the store to capacity, then overflow it once.
    for (int unsigned i = 1; i <= 12; i++) push_op(OP_INSERT, 32'h1000_0000 * i);
    push_op(OP_INSERT, 32'h1234_5678);
    push_op(OP_REMOVE, 32'h0);
    push_op(OP_CLEAR, 32'h0);

    // Random phases alternate the compare mode. Keys are not cleared between
    // phases, so the mode often changes while the queue holds entries.
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_mode(p % 2 == 0);
      run_random(ITEMS_PER_PHASE, p == 2);
    end

    drain_results();
    repeat (8) @(negedge clk_i);

    $display("Covered %0d operations with %0d results checked, in both compare modes.",
             tracker.n_ops, tracker.n_checked);
    $display("Removals %0d, removes on an empty queue %0d, inserts dropped at full %0d.",
             tracker.n_removed, tracker.n_empty, tracker.n_full);
    if (tracker.errors == 0 && tracker.outcome_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sorted_max_priority_queue.f
hdl/smpq_pkg.sv
hdl/smpq_cell.sv
hdl/sorted_max_priority_queue.sv
test/tb_sorted_max_priority_queue.sv
